/* sv/iasr_pkg.sv */
`timescale 1ns / 1ps

package iasr_pkg;

  // storage geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  // packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_BITS  = OP_W + POS_W + DATA_W;
  localparam int unsigned OUT_BITS = DATA_W + STATUS_W + CNT_OUT_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // minus one billion, returned on an out-of-bounds read
  localparam logic signed [DATA_W-1:0] OOB_READ_WORD = 32'shC465_3600;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_APPEND = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_DATA,
    S_SHIFT,
    S_RESP
  } state_e;

  // one write port and one read port of the element store
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [ADDR_W-1:0]        raddr;
  } ram_req_t;

  // finished command result handed to the output register
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
    logic [CNT_OUT_W-1:0]     element_count;
  } result_t;

endpackage

/* sv/iasr_ram.sv */
`timescale 1ns / 1ps

module iasr_ram (
  input  logic                                     clk_i,
  input  iasr_pkg::ram_req_t                       req_i,
  output logic signed [iasr_pkg::DATA_W-1:0]       rdata_o
);

  logic signed [iasr_pkg::DATA_W-1:0] mem_q [iasr_pkg::CAPACITY];
  logic signed [iasr_pkg::DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port, holds its data while idle
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/iasr_ctrl.sv */
`timescale 1ns / 1ps

module iasr_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_fire_i,
  input  iasr_pkg::op_e                        opcode_i,
  input  logic [iasr_pkg::POS_W-1:0]           position_i,
  input  logic signed [iasr_pkg::DATA_W-1:0]   value_i,
  input  logic                                 out_free_i,
  input  logic signed [iasr_pkg::DATA_W-1:0]   ram_rdata_i,
  output logic                                 idle_o,
  output iasr_pkg::ram_req_t                   ram_req_o,
  output iasr_pkg::result_t                    result_o
);

  iasr_pkg::state_e                     state_q, state_d;
  iasr_pkg::op_e                        op_q;
  logic [iasr_pkg::POS_W-1:0]           pos_q;
  logic signed [iasr_pkg::DATA_W-1:0]   val_q;
  logic [iasr_pkg::CNT_W-1:0]           count_q, count_d;
  logic [iasr_pkg::CNT_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [iasr_pkg::ADDR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic                                 pend_q, pend_d;
  logic signed [iasr_pkg::DATA_W-1:0]   rd_value_q, rd_value_d;
  iasr_pkg::status_e                    status_q, status_d;
  logic                                 in_range;
  logic [iasr_pkg::CNT_W-1:0]           pos_cnt;

  assign in_range = iasr_pkg::CMP_W'(pos_q) < iasr_pkg::CMP_W'(count_q);
  // only used once the position is known to be below the count
  assign pos_cnt  = iasr_pkg::CNT_W'(pos_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= iasr_pkg::S_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
    end
  end

  // command and working registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    rd_ptr_q   <= rd_ptr_d;
    wr_ptr_q   <= wr_ptr_d;
    rd_value_q <= rd_value_d;
    status_q   <= status_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    pend_d     = pend_q;
    rd_value_d = rd_value_q;
    status_d   = status_q;
    ram_req_o  = '0;
    result_o   = '0;

    unique case (state_q)
      iasr_pkg::S_IDLE: begin
        if (in_fire_i) begin
          state_d = iasr_pkg::S_EXEC;
        end
      end

      iasr_pkg::S_EXEC: begin
        rd_value_d = '0;
        status_d   = iasr_pkg::ST_OK;
        state_d    = iasr_pkg::S_RESP;
        unique case (op_q)
          iasr_pkg::OP_READ: begin
            if (in_range) begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = pos_cnt[iasr_pkg::ADDR_W-1:0];
              state_d         = iasr_pkg::S_RD_DATA;
            end else begin
              rd_value_d = iasr_pkg::OOB_READ_WORD;
              status_d   = iasr_pkg::ST_OOB;
            end
          end
          iasr_pkg::OP_WRITE: begin
            if (in_range) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = pos_cnt[iasr_pkg::ADDR_W-1:0];
              ram_req_o.wdata = val_q;
            end else begin
              status_d = iasr_pkg::ST_OOB;
            end
          end
          iasr_pkg::OP_APPEND: begin
            if (count_q < iasr_pkg::CNT_W'(iasr_pkg::CAPACITY)) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = count_q[iasr_pkg::ADDR_W-1:0];
              ram_req_o.wdata = val_q;
              count_d         = count_q + 1'b1;
            end else begin
              status_d = iasr_pkg::ST_FULL;
            end
          end
          iasr_pkg::OP_REMOVE: begin
            if (in_range) begin
              rd_ptr_d = pos_cnt + 1'b1;
              wr_ptr_d = pos_cnt[iasr_pkg::ADDR_W-1:0];
              pend_d   = 1'b0;
              state_d  = iasr_pkg::S_SHIFT;
            end else begin
              status_d = iasr_pkg::ST_OOB;
            end
          end
          default: begin
            status_d = iasr_pkg::ST_OOB;
          end
        endcase
      end

      iasr_pkg::S_RD_DATA: begin
        rd_value_d = ram_rdata_i;
        state_d    = iasr_pkg::S_RESP;
      end

      // read one entry ahead while writing the previous one a place lower
      iasr_pkg::S_SHIFT: begin
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = wr_ptr_q;
          ram_req_o.wdata = ram_rdata_i;
          wr_ptr_d        = wr_ptr_q + 1'b1;
        end
        if (rd_ptr_q < count_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = rd_ptr_q[iasr_pkg::ADDR_W-1:0];
          rd_ptr_d        = rd_ptr_q + 1'b1;
          pend_d          = 1'b1;
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - 1'b1;
          state_d = iasr_pkg::S_RESP;
        end
      end

      iasr_pkg::S_RESP: begin
        if (out_free_i) begin
          result_o.valid         = 1'b1;
          result_o.read_value    = rd_value_q;
          result_o.status        = status_q;
          result_o.element_count = iasr_pkg::CNT_OUT_W'(count_q);
          state_d                = iasr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = iasr_pkg::S_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == iasr_pkg::S_IDLE);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iasr_pkg::CNT_W'(iasr_pkg::CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
             (count_q + 1'b1 == $past(count_q)))
    else $error("element count moved by more than one");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iasr_pkg::S_IDLE) |-> !ram_req_o.we && !ram_req_o.re)
    else $error("store accessed while idle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status == iasr_pkg::ST_FULL) |->
      count_q == iasr_pkg::CNT_W'(iasr_pkg::CAPACITY))
    else $error("full status with room left");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |=> state_q == iasr_pkg::S_IDLE)
    else $error("result without return to idle");

endmodule

/* sv/indexed_array_with_shift_remove_top.sv */
`timescale 1ns / 1ps
// sequence: every command passes S_EXEC then S_RESP; a read in range also passes
//   S_RD_DATA, and a remove in range shifts each later word down a place in S_SHIFT
// throughput: one command at a time; the next is taken once the previous result
//   sits in the output register, so a remove holds off the next command while its
//   shift runs through the single read and single write port of the element store
// reset: asynchronous active low, clears count and handshake state; stored words kept

module indexed_array_with_shift_remove_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // opcode [1:0], position [9:2], value [41:10], zero pad above
  input  logic [iasr_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // read_value [31:0], status [33:32], element_count [42:34], zero pad above
  output logic [iasr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned POS_LO = iasr_pkg::OP_W;
  localparam int unsigned VAL_LO = iasr_pkg::OP_W + iasr_pkg::POS_W;

  logic                                 in_fire;
  logic                                 idle;
  logic                                 out_free;
  iasr_pkg::ram_req_t                   ram_req;
  logic signed [iasr_pkg::DATA_W-1:0]   ram_rdata;
  iasr_pkg::result_t                    result;
  logic                                 m_valid_q;
  logic [iasr_pkg::OUT_TDATA_W-1:0]     m_data_q;

  // input handshake
  assign s_axis_tready_o = idle;
  assign in_fire         = s_axis_tvalid_i && idle;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  iasr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .opcode_i    (iasr_pkg::op_e'(s_axis_tdata_i[iasr_pkg::OP_W-1:0])),
    .position_i  (s_axis_tdata_i[POS_LO +: iasr_pkg::POS_W]),
    .value_i     (s_axis_tdata_i[VAL_LO +: iasr_pkg::DATA_W]),
    .out_free_i  (out_free),
    .ram_rdata_i (ram_rdata),
    .idle_o      (idle),
    .ram_req_o   (ram_req),
    .result_o    (result)
  );

  iasr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (result.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      m_data_q <= iasr_pkg::OUT_TDATA_W'({result.element_count, result.status,
                                          result.read_value});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import iasr_pkg::*;

  // one predicted result of a command
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
    logic [CNT_OUT_W-1:0]     element_count;
  } array_result_t;

  // shadow copy of the array; predicts each result and checks the returned ones
  class array_scoreboard;
    logic signed [DATA_W-1:0] words[CAPACITY];
    int unsigned              count;
    array_result_t            awaited_q[$];
    int unsigned              errors;
    int unsigned              op_seen[4];
    int unsigned              oob_seen;
    int unsigned              full_seen;
    int unsigned              peak_count;
    int unsigned              results_seen;

    function new();
      count        = 0;
      errors       = 0;
      oob_seen     = 0;
      full_seen    = 0;
      peak_count   = 0;
      results_seen = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    // apply one accepted command to the shadow array
    function void note_command(op_e op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
      array_result_t r;
      int unsigned   i;
      r.read_value = '0;
      r.status     = ST_OK;
      case (op)
        OP_READ: begin
          if (pos < count) begin
            r.read_value = words[pos];
          end else begin
            r.read_value = OOB_READ_WORD;
            r.status     = ST_OOB;
          end
        end
        OP_WRITE: begin
          if (pos < count) words[pos] = val;
          else r.status = ST_OOB;
        end
        OP_APPEND: begin
          if (count < CAPACITY) begin
            words[count] = val;
            count++;
          end else begin
            r.status = ST_FULL;
          end
        end
        default: begin
          if (pos < count) begin
            // close the gap by moving later words down one place
            for (i = pos; i + 1 < count; i++) words[i] = words[i+1];
            count--;
          end else begin
            r.status = ST_OOB;
          end
        end
      endcase
      r.element_count = CNT_OUT_W'(count);
      op_seen[op]++;
      if (r.status == ST_OOB) oob_seen++;
      if (r.status == ST_FULL) full_seen++;
      if (count > peak_count) peak_count = count;
      awaited_q.push_back(r);
    endfunction

    function void report(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      errors++;
      if (errors <= 30)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
    endfunction

    // compare one output transfer with the oldest prediction
    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      array_result_t exp_r;
      logic signed [DATA_W-1:0] act_value;
      logic [STATUS_W-1:0]      act_status;
      logic [CNT_OUT_W-1:0]     act_count;
      act_value  = tdata[DATA_W-1:0];
      act_status = tdata[DATA_W +: STATUS_W];
      act_count  = tdata[DATA_W+STATUS_W +: CNT_OUT_W];
      results_seen++;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t ns: result with nothing awaited, expected none actual %h", $time, tdata);
        return;
      end
      exp_r = awaited_q.pop_front();
      if (act_value !== exp_r.read_value)
        report("read_value", exp_r.read_value, act_value);
      if (act_status !== exp_r.status)
        report("status", DATA_W'(exp_r.status), DATA_W'(act_status));
      if (act_count !== exp_r.element_count)
        report("element_count", DATA_W'(exp_r.element_count), DATA_W'(act_count));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  array_scoreboard sb;
  bit              steady_flow;

  indexed_array_with_shift_remove_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= steady_flow || ($urandom_range(0, 99) >= 12);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // offer one command and hold it until the transfer
  task automatic send_cmd(op_e op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({val, pos, op});
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(op, pos, val);
  endtask

  // random command, mostly with positions inside the array
  task automatic rand_cmd(int unsigned append_pct, int unsigned remove_pct);
    int unsigned      r;
    op_e              op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < append_pct) op = OP_APPEND;
    else if (r < append_pct + remove_pct) op = OP_REMOVE;
    else op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
    if (sb.count > 0 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, sb.count - 1));
    else pos = POS_W'($urandom());
    send_cmd(op, pos, $urandom());
  endtask

  initial begin
    int unsigned n;
    sb              = new();
    steady_flow     = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty array: every indexed command is out of bounds
    send_cmd(OP_READ,   8'd0,   32'h0);
    send_cmd(OP_WRITE,  8'd0,   32'h5A5A_5A5A);
    send_cmd(OP_REMOVE, 8'd0,   32'h0);
    // value extremes
    send_cmd(OP_APPEND, 8'd0,   32'h7FFF_FFFF);
    send_cmd(OP_APPEND, 8'd255, 32'h8000_0000);
    send_cmd(OP_APPEND, 8'd0,   32'h0000_0000);
    send_cmd(OP_APPEND, 8'd0,   32'hFFFF_FFFF);
    for (n = 0; n < 4; n++) send_cmd(OP_READ, POS_W'(n), 32'h0);
    // position at count and at the top
    send_cmd(OP_READ,   8'd4,   32'h0);
    send_cmd(OP_READ,   8'd255, 32'h0);
    send_cmd(OP_WRITE,  8'd1,   32'h1234_5678);
    send_cmd(OP_WRITE,  8'd4,   32'hDEAD_BEEF);
    send_cmd(OP_READ,   8'd1,   32'h0);
    // remove from the middle, the end and the front
    send_cmd(OP_REMOVE, 8'd1,   32'h0);
    send_cmd(OP_READ,   8'd1,   32'h0);
    send_cmd(OP_REMOVE, 8'd2,   32'h0);
    send_cmd(OP_REMOVE, 8'd0,   32'h0);
    send_cmd(OP_READ,   8'd0,   32'h0);
    send_cmd(OP_REMOVE, 8'd0,   32'h0);
    send_cmd(OP_REMOVE, 8'd255, 32'h0);
    send_cmd(OP_READ,   8'd0,   32'h0);

    // grow to capacity with mixed traffic, one stretch without idling
    n = 0;
    while (sb.count < CAPACITY) begin
      steady_flow = (n >= 60 && n < 180);
      rand_cmd(85, 5);
      n++;
    end
    steady_flow = 1'b0;

    // full array: appends rejected, top position now valid
    repeat (5) send_cmd(OP_APPEND, POS_W'($urandom()), $urandom());
    send_cmd(OP_WRITE,  8'd255, 32'h8000_0001);
    send_cmd(OP_READ,   8'd255, 32'h0);
    send_cmd(OP_REMOVE, 8'd0,   32'h0);
    send_cmd(OP_APPEND, 8'd0,   32'h7FFF_FFFE);
    send_cmd(OP_READ,   8'd255, 32'h0);
    send_cmd(OP_REMOVE, 8'd255, 32'h0);

    // hold off until the array has drained its results
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);

    // balanced traffic at high occupancy
    repeat (130) rand_cmd(30, 30);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("commands: %0d read, %0d write, %0d append, %0d remove; %0d results checked",
             sb.op_seen[OP_READ], sb.op_seen[OP_WRITE], sb.op_seen[OP_APPEND],
             sb.op_seen[OP_REMOVE], sb.results_seen);
    $display("out of bounds %0d, full rejects %0d, peak count %0d, errors %0d",
             sb.oob_seen, sb.full_seen, sb.peak_count, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* indexed_array_with_shift_remove_top.f */
sv/iasr_pkg.sv
sv/iasr_ram.sv
sv/iasr_ctrl.sv
sv/indexed_array_with_shift_remove_top.sv
verif/tb.sv
